[rtl/core/local_history_branch_predictor_defines.svh]
// assertion macros for the checker file of the branch predictor
// no dependencies; every use needs clk in scope, and LHBP_ASSERT also needs arst_n
`ifndef LOCAL_HISTORY_BRANCH_PREDICTOR_DEFINES_SVH
`define LOCAL_HISTORY_BRANCH_PREDICTOR_DEFINES_SVH

// property checked only while out of reset
`define LHBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define LHBP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/lhbp_pkg.sv]
// types, constants and counter functions of the local history branch predictor
// no dependencies; used by all predictor modules
package lhbp_pkg;

	localparam int PC_INDEX_BITS = 15;
	localparam int HISTORY_BITS  = 5;
	localparam int PC_W          = 32;
	localparam int HIST_DEPTH    = 2 ** PC_INDEX_BITS;
	localparam int PAT_DEPTH     = 2 ** HISTORY_BITS;
	localparam int S_TDATA_W     = ((PC_W + 1 + 7) / 8) * 8;
	localparam int M_TDATA_W     = 8;

	typedef logic [PC_INDEX_BITS-1:0] slot_t;
	typedef logic [HISTORY_BITS-1:0]  hist_t;
	typedef logic [1:0]               ctr_t;

	// counter codes
	localparam ctr_t CTR_STRONG_TAKEN     = 2'd0;
	localparam ctr_t CTR_WEAK_TAKEN       = 2'd1;
	localparam ctr_t CTR_WEAK_NOT_TAKEN   = 2'd2;
	localparam ctr_t CTR_STRONG_NOT_TAKEN = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	// counter update request to the pattern table
	typedef struct packed {
		logic  en;
		hist_t idx;
		logic  taken;
	} pat_upd_t;

	function automatic logic ctr_predict(ctr_t c);
		return (c < CTR_WEAK_NOT_TAKEN);
	endfunction

	// saturating move toward taken or not taken
	function automatic ctr_t ctr_train(ctr_t c, logic taken);
		ctr_t r;
		r = c;
		if (taken) begin
			if (c != CTR_STRONG_TAKEN) r = c - ctr_t'(1);
		end else begin
			if (c != CTR_STRONG_NOT_TAKEN) r = c + ctr_t'(1);
		end
		return r;
	endfunction

	// shift the outcome in at the low end
	function automatic hist_t next_history(hist_t h, logic taken);
		return hist_t'({h, taken});
	endfunction

endpackage

[rtl/core/lhbp_hist_mem.sv]
// per-branch history memory: one write port, one registered read port
// depends on lhbp_pkg
module lhbp_hist_mem (
	input  logic                clk,
	input  logic                rd_en,
	input  lhbp_pkg::slot_t     rd_addr,
	output lhbp_pkg::hist_t     rd_data,
	input  logic                wr_en,
	input  lhbp_pkg::slot_t     wr_addr,
	input  lhbp_pkg::hist_t     wr_data
);

	lhbp_pkg::hist_t mem [lhbp_pkg::HIST_DEPTH];
	lhbp_pkg::hist_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	// read port, data valid in the cycle after the read
	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/lhbp_pattern_table.sv]
// shared table of 2-bit saturating counters indexed by branch history
// depends on lhbp_pkg
module lhbp_pattern_table (
	input  logic               clk,
	input  logic               arst_n,
	input  lhbp_pkg::hist_t    rd_idx,
	output lhbp_pkg::ctr_t     rd_ctr,
	input  lhbp_pkg::pat_upd_t upd
);

	lhbp_pkg::ctr_t ctr_q [lhbp_pkg::PAT_DEPTH];

	// combinational lookup
	assign rd_ctr = ctr_q[rd_idx];

	// counter update, cleared to strongly taken at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lhbp_pkg::PAT_DEPTH; i++) begin
				ctr_q[i] <= lhbp_pkg::CTR_STRONG_TAKEN;
			end
		end else if (upd.en) begin
			ctr_q[upd.idx] <= lhbp_pkg::ctr_train(ctr_q[upd.idx], upd.taken);
		end
	end

endmodule

[rtl/core/local_history_branch_predictor.sv]
// Two-level local branch predictor. A request passes ST_IDLE and ST_LOOKUP: the
// accept cycle reads the branch's history from the history memory, whose read
// port is registered; ST_LOOKUP then looks up the pattern counter and, once the
// output register is free, registers the prediction and, for a train request,
// writes the new history and counter. One request is in flight at a time, so
// no new request is accepted until the last one has left ST_LOOKUP; a waiting
// result does not block the next request from being accepted. After reset the
// history memory is cleared one entry per cycle, all 32768 entries
// (2^PC_INDEX_BITS), during which s_tready stays low.
// depends on lhbp_pkg, lhbp_hist_mem, lhbp_pattern_table
module local_history_branch_predictor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lhbp_pkg::S_TDATA_W-1:0] s_tdata,  // pc[31:0], taken[32], zero pad
	input  logic                           s_tuser,  // mode[0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lhbp_pkg::M_TDATA_W-1:0] m_tdata   // predict_taken[0], zero pad
);

	lhbp_pkg::state_t   state_q, state_d;
	lhbp_pkg::slot_t    clr_idx_q;
	lhbp_pkg::slot_t    slot_s1;
	logic               train_s1;
	logic               taken_s1;
	logic               m_valid_q;
	logic               m_pred_q;

	logic               accept;
	logic               out_free;
	logic               lookup_done;
	logic               clr_inc;
	lhbp_pkg::hist_t    hist_rd;
	lhbp_pkg::ctr_t     ctr_rd;
	logic               mem_wr_en;
	lhbp_pkg::slot_t    mem_wr_addr;
	lhbp_pkg::hist_t    mem_wr_data;
	lhbp_pkg::pat_upd_t pat_upd;

	assign accept   = s_tvalid & s_tready;
	assign out_free = !m_valid_q | m_tready;

	// history memory
	lhbp_hist_mem u_hist_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (s_tdata[lhbp_pkg::PC_INDEX_BITS-1:0]),
		.rd_data (hist_rd),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	// pattern counters
	lhbp_pattern_table u_pat (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (hist_rd),
		.rd_ctr (ctr_rd),
		.upd    (pat_upd)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lhbp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory write and counter update
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		lookup_done = 1'b0;
		clr_inc     = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = slot_s1;
		mem_wr_data = lhbp_pkg::next_history(hist_rd, taken_s1);
		pat_upd     = '{en: 1'b0, idx: hist_rd, taken: taken_s1};
		unique case (state_q)
			lhbp_pkg::ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_idx_q;
				mem_wr_data = '0;
				clr_inc     = 1'b1;
				if (clr_idx_q == '1) state_d = lhbp_pkg::ST_IDLE;
			end
			lhbp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = lhbp_pkg::ST_LOOKUP;
			end
			lhbp_pkg::ST_LOOKUP: begin
				if (out_free) begin
					lookup_done = 1'b1;
					mem_wr_en   = train_s1;
					pat_upd.en  = train_s1;
					state_d     = lhbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lhbp_pkg::ST_IDLE;
			end
		endcase
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (clr_inc) begin
			clr_idx_q <= clr_idx_q + lhbp_pkg::slot_t'(1);
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1  <= s_tdata[lhbp_pkg::PC_INDEX_BITS-1:0];
			taken_s1 <= s_tdata[lhbp_pkg::PC_W];
			train_s1 <= s_tuser;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (lookup_done) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_done) m_pred_q <= lhbp_pkg::ctr_predict(ctr_rd);
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(lhbp_pkg::M_TDATA_W-1){1'b0}}, m_pred_q};

endmodule

[rtl/core/lhbp_checker.sv]
// port-level checks for the local history branch predictor, bound to the top level
// depends on lhbp_pkg and local_history_branch_predictor_defines.svh
`include "local_history_branch_predictor_defines.svh"

module lhbp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [lhbp_pkg::M_TDATA_W-1:0] m_tdata
);

	// no result and no request taken while in reset
	`LHBP_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (!m_tvalid && !s_tready), "active port during reset")

	// a stalled result holds
	`LHBP_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result dropped or changed while stalled")

	// one request in flight: no accept in the cycle after an accept
	`LHBP_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "request accepted while another is in flight")

	// a new result only appears for a matching accepted request
	`LHBP_ASSERT(a_result_timing, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result without matching request")

endmodule

bind local_history_branch_predictor lhbp_checker u_lhbp_checker (.*);

[sim/local_history_branch_predictor_tb.sv]
// self-checking bench for the local history branch predictor: directed and random requests,
// predictions checked against a behavioral copy of the history and counter tables
// depends on lhbp_pkg and local_history_branch_predictor
`timescale 1ns / 1ps

module local_history_branch_predictor_tb;

	localparam logic MODE_PREDICT = 1'b0;
	localparam logic MODE_TRAIN   = 1'b1;
	localparam int   RAND_REQS    = 400;
	localparam int   MAX_IDLE     = 13;
	localparam int   HOLD_CYCLES  = 300;
	localparam int   HOT_SLOTS    = 8;

	typedef struct packed {
		logic        mode;
		logic [31:0] pc;
		logic        taken;
		logic        typed;
		logic        guess;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [lhbp_pkg::S_TDATA_W-1:0] s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [lhbp_pkg::M_TDATA_W-1:0] m_tdata;

	// behavioral copy of the two tables
	lhbp_pkg::hist_t slot_hist [lhbp_pkg::HIST_DEPTH];
	lhbp_pkg::ctr_t  pattern_ctr [lhbp_pkg::PAT_DEPTH];

	logic      guess_q [$];
	stim_row_t dir_rows [$];
	int        errors = 0;
	bit        calm = 1'b0;
	bit        hold_off = 1'b0;

	local_history_branch_predictor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// prediction from the current tables, then the update of a train request
	function automatic logic branch_guess(logic mode, logic [31:0] pc, logic taken);
		lhbp_pkg::slot_t s;
		lhbp_pkg::hist_t h;
		lhbp_pkg::ctr_t  c;
		logic            guess;
		s = pc[lhbp_pkg::PC_INDEX_BITS-1:0];
		h = slot_hist[s];
		c = pattern_ctr[h];
		guess = (c == lhbp_pkg::CTR_STRONG_TAKEN) || (c == lhbp_pkg::CTR_WEAK_TAKEN);
		if (mode == MODE_TRAIN) begin
			if (taken && c != lhbp_pkg::CTR_STRONG_TAKEN)
				c = c - 2'd1;
			else if (!taken && c != lhbp_pkg::CTR_STRONG_NOT_TAKEN)
				c = c + 2'd1;
			pattern_ctr[h] = c;
			slot_hist[s] = {h[lhbp_pkg::HISTORY_BITS-2:0], taken};
		end
		return guess;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic add_row(input logic mode, input logic [31:0] pc, input logic taken,
			input logic typed, input logic guess);
		stim_row_t r;
		r.mode = mode;
		r.pc = pc;
		r.taken = taken;
		r.typed = typed;
		r.guess = guess;
		dir_rows.push_back(r);
	endtask

	function automatic int draw_idle();
		return calm ? 0 : int'($urandom_range(0, MAX_IDLE));
	endfunction

	// present one request and keep it until accepted, then record its prediction
	task automatic offer_request(input logic mode, input logic [31:0] pc, input logic taken,
			input logic typed, input logic guess);
		logic [lhbp_pkg::S_TDATA_W-1:0] word;
		logic                           model;
		word = '0;
		word[31:0] = pc;
		word[32] = taken;
		s_tdata <= word;
		s_tuser <= mode;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		model = branch_guess(mode, pc, taken);
		guess_q.push_back(typed ? guess : model);
	endtask

	// sender: reset, directed rows, random requests, drain
	initial begin
		logic [31:0]   hot_pc [HOT_SLOTS];
		int            hot_period [HOT_SLOTS];
		int            hot_iter [HOT_SLOTS];
		int            gap;
		int            k;
		logic          mode;
		logic [31:0]   pc;
		logic          taken;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= MODE_PREDICT;
		for (int i = 0; i < lhbp_pkg::HIST_DEPTH; i++)
			slot_hist[i] = '0;
		for (int i = 0; i < lhbp_pkg::PAT_DEPTH; i++)
			pattern_ctr[i] = lhbp_pkg::CTR_STRONG_TAKEN;

		// after reset everything predicts taken
		add_row(MODE_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b1);
		add_row(MODE_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		add_row(MODE_PREDICT, 32'h0000_7FFF, 1'b0, 1'b1, 1'b1);
		add_row(MODE_TRAIN,   32'h0000_0000, 1'b0, 1'b1, 1'b1);
		// drive counter of history zero up to strongly not taken and past it
		add_row(MODE_TRAIN,   32'h0000_0000, 1'b0, 1'b0, 1'b0);
		add_row(MODE_TRAIN,   32'h0000_0000, 1'b0, 1'b0, 1'b0);
		add_row(MODE_TRAIN,   32'h0000_0000, 1'b0, 1'b0, 1'b0);
		// aliased address, predict only, taken must be ignored
		add_row(MODE_PREDICT, 32'hFFFF_8000, 1'b1, 1'b0, 1'b0);
		add_row(MODE_PREDICT, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
		// fill the top slot's history with taken outcomes
		for (int i = 0; i < 6; i++)
			add_row(MODE_TRAIN, 32'h0000_7FFF, 1'b1, 1'b0, 1'b0);
		add_row(MODE_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		add_row(MODE_TRAIN,   32'h0000_7FFF, 1'b0, 1'b0, 1'b0);
		add_row(MODE_TRAIN,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		add_row(MODE_TRAIN,   32'h1234_5678, 1'b1, 1'b0, 1'b0);
		add_row(MODE_PREDICT, 32'hEDCB_D678, 1'b0, 1'b0, 1'b0);
		add_row(MODE_TRAIN,   32'h8000_0000, 1'b1, 1'b0, 1'b0);
		add_row(MODE_PREDICT, 32'h5555_AAAA, 1'b1, 1'b0, 1'b0);
		add_row(MODE_TRAIN,   32'hAAAA_5555, 1'b1, 1'b0, 1'b0);

		for (int i = 0; i < HOT_SLOTS; i++) begin
			hot_pc[i] = $urandom;
			hot_period[i] = $urandom_range(2, 7);
			hot_iter[i] = 0;
		end
		hot_pc[0][lhbp_pkg::PC_INDEX_BITS-1:0] = '0;
		hot_pc[1][lhbp_pkg::PC_INDEX_BITS-1:0] = '1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			gap = draw_idle();
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			offer_request(dir_rows[i].mode, dir_rows[i].pc, dir_rows[i].taken,
				dir_rows[i].typed, dir_rows[i].guess);
		end

		// random part: mostly recurring branches with loop-like outcome patterns
		for (int n = 0; n < RAND_REQS; n++) begin
			if (n % 50 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (n == 150)
				hold_off = 1'b1;
			if (n == 300) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (guess_q.size() != 0);
			end
			gap = draw_idle();
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if ($urandom_range(0, 9) < 7) begin
				k = $urandom_range(0, HOT_SLOTS - 1);
				pc = $urandom;
				pc[lhbp_pkg::PC_INDEX_BITS-1:0] = hot_pc[k][lhbp_pkg::PC_INDEX_BITS-1:0];
				taken = (hot_iter[k] % hot_period[k]) != (hot_period[k] - 1);
				if ($urandom_range(0, 6) == 0)
					taken = 1'($urandom_range(0, 1));
				hot_iter[k]++;
			end else begin
				pc = $urandom;
				taken = 1'($urandom_range(0, 1));
			end
			mode = ($urandom_range(0, 9) < 7) ? MODE_TRAIN : MODE_PREDICT;
			offer_request(mode, pc, taken, 1'b0, 1'b0);
		end
		s_tvalid <= 1'b0;

		while (guess_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// receiver: random stalls, one long hold-off, prediction check
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = draw_idle();
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (guess_q.size() == 0)
				report_mismatch($sformatf("unexpected prediction %0b", m_tdata[0]));
			else if (m_tdata[0] !== guess_q[0])
				report_mismatch($sformatf("predict_taken %0b, want %0b",
					m_tdata[0], guess_q.pop_front()));
			else
				void'(guess_q.pop_front());
		end
	end

	// run limit, covers the table clear after reset
	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
